[design/gme_pkg.sv]
// ----------------------------------------------------------------------------
// gme_pkg: shared types and constants of the gradient magnitude edge map
// Holds the size limits, arithmetic constants and the control/status structs
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gme_pkg;

    // Default frame limits for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Width of a clamped frame dimension (covers 11-bit registers and 8192)
    localparam int SIZE_W = 14;
    // Width of a configuration register field
    localparam int CFG_W = 11;
    // Reset frame size
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // Pixel intensity: sum of three 8-bit channels
    localparam int CHAN_W = 8;
    localparam int INTEN_W = 10;
    // Signed difference of two intensities
    localparam int DIFF_W = INTEN_W + 1;
    // Sum of two squared differences
    localparam int SQ_W = 21;
    // Square root result width and iteration count
    localparam int ROOT_W = 11;
    localparam int ROOT_STEPS = 11;
    localparam int STEP_W = 4;

    // Division by three as multiply by reciprocal: floor(v / 3) = (v * 43691) >> 17
    localparam int RECIP_W = 17;
    localparam logic [RECIP_W-1:0] RECIP_THIRD = 17'd43691;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W = ROOT_W + RECIP_W;

    // Output level
    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Clamped frame size
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } gme_size_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic diff;
        logic square;
        logic root_step;
        logic scale;
        logic emit_edge;
        logic emit_zero;
    } gme_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic has_edge;
        logic has_zero;
        logic root_last;
        logic out_busy;
    } gme_status_t;

endpackage

[design/gme_pixel_if.sv]
// ----------------------------------------------------------------------------
// gme_pixel_if: pixel stream channel
// Carries one RGB pixel per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gme_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [gme_pkg::CHAN_W-1:0]  red;
    logic [gme_pkg::CHAN_W-1:0]  green;
    logic [gme_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[design/gme_edge_if.sv]
// ----------------------------------------------------------------------------
// gme_edge_if: edge level stream channel
// Carries one edge level and its end-of-frame mark per transfer.
// ----------------------------------------------------------------------------
interface gme_edge_if;
    logic                        valid;
    logic                        ready;
    logic [gme_pkg::LEVEL_W-1:0] edge_level;
    logic                        last_of_frame;

    modport source (output valid, output edge_level, output last_of_frame, input ready);
    modport sink   (input valid, input edge_level, input last_of_frame, output ready);
endinterface

[design/gme_regs.sv]
// ----------------------------------------------------------------------------
// gme_regs: configuration registers
// APB-style write/read of the frame width and height, and clamping of both
// to the range the datapath supports.
// ----------------------------------------------------------------------------
module gme_regs #(
    parameter int MAX_WIDTH  = gme_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gme_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gme_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [gme_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [gme_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output gme_pkg::gme_size_t                size
);

    localparam logic [gme_pkg::SIZE_W-1:0] MIN_SIZE = gme_pkg::SIZE_W'(2);
    localparam logic [gme_pkg::SIZE_W-1:0] MAX_W    = gme_pkg::SIZE_W'(MAX_WIDTH);
    localparam logic [gme_pkg::SIZE_W-1:0] MAX_H    = gme_pkg::SIZE_W'(MAX_HEIGHT);

    logic [gme_pkg::CFG_W-1:0]  width_reg;
    logic [gme_pkg::CFG_W-1:0]  height_reg;
    logic [gme_pkg::SIZE_W-1:0] width_ext;
    logic [gme_pkg::SIZE_W-1:0] height_ext;
    logic                       reg_sel;
    logic                       wr_en;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gme_pkg::WIDTH_RESET;
            height_reg <= gme_pkg::HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                gme_pkg::REG_WIDTH:  width_reg  <= pwdata[gme_pkg::CFG_W-1:0];
                gme_pkg::REG_HEIGHT: height_reg <= pwdata[gme_pkg::CFG_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_sel)
            gme_pkg::REG_WIDTH:  prdata = gme_pkg::APB_DATA_W'(width_reg);
            gme_pkg::REG_HEIGHT: prdata = gme_pkg::APB_DATA_W'(height_reg);
            default:             prdata = '0;
        endcase
    end

    // Clamp the size to [2, maximum]
    assign width_ext  = gme_pkg::SIZE_W'(width_reg);
    assign height_ext = gme_pkg::SIZE_W'(height_reg);

    always_comb
    begin
        if (width_ext < MIN_SIZE)
            size.width = MIN_SIZE;
        else if (width_ext > MAX_W)
            size.width = MAX_W;
        else
            size.width = width_ext;

        if (height_ext < MIN_SIZE)
            size.height = MIN_SIZE;
        else if (height_ext > MAX_H)
            size.height = MAX_H;
        else
            size.height = height_ext;
    end

endmodule

[design/gme_ctrl.sv]
// ----------------------------------------------------------------------------
// gme_ctrl: pixel sequencer
// Steps each accepted pixel through line read, difference and, for an edge
// pixel, square, root iteration and scaling, and up to two output transfers.
// ----------------------------------------------------------------------------
module gme_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gme_pkg::gme_status_t  status,
    output gme_pkg::gme_cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DIFF      = 7'b0000010,
        ST_SQUARE    = 7'b0000100,
        ST_ROOT      = 7'b0001000,
        ST_SCALE     = 7'b0010000,
        ST_EMIT_EDGE = 7'b0100000,
        ST_EMIT_ZERO = 7'b1000000
    } gme_state_t;

    gme_state_t state_reg;
    gme_state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff = 1'b1;
                if (status.has_edge)
                    state_next = ST_SQUARE;
                else if (status.has_zero)
                    state_next = ST_EMIT_ZERO;
                else
                    state_next = ST_IDLE;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT_EDGE;
            end
            ST_EMIT_EDGE:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_edge = 1'b1;
                    state_next    = status.has_zero ? ST_EMIT_ZERO : ST_IDLE;
                end
            end
            ST_EMIT_ZERO:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_zero = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/gme_dp.sv]
// ----------------------------------------------------------------------------
// gme_dp: edge map datapath
// Raster counters, previous-row line memory, neighbor registers, squared
// difference, bit-pair square root, divide by three and the output register.
// ----------------------------------------------------------------------------
module gme_dp #(
    parameter int MAX_WIDTH  = gme_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gme_pkg::MAX_HEIGHT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gme_pkg::gme_size_t           size,
    input  gme_pkg::gme_cmd_t            cmd,
    output gme_pkg::gme_status_t         status,
    input  logic [gme_pkg::CHAN_W-1:0]   red,
    input  logic [gme_pkg::CHAN_W-1:0]   green,
    input  logic [gme_pkg::CHAN_W-1:0]   blue,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gme_pkg::LEVEL_W-1:0]  edge_level,
    output logic                         last_of_frame
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [gme_pkg::STEP_W-1:0] STEP_FIRST = gme_pkg::STEP_W'(gme_pkg::ROOT_STEPS - 1);

    // Raster position
    logic [COL_W-1:0]           col_reg;
    logic [ROW_W-1:0]           row_reg;
    logic                       last_col;
    logic                       last_row;

    // Line memory of previous-row intensities
    logic [gme_pkg::INTEN_W-1:0] line_mem [MAX_WIDTH];
    logic [gme_pkg::INTEN_W-1:0] above_reg;
    logic [gme_pkg::INTEN_W-1:0] inten;
    logic [gme_pkg::INTEN_W-1:0] pix_reg;

    // Neighbor intensities
    logic [gme_pkg::INTEN_W-1:0] left_reg;
    logic [gme_pkg::INTEN_W-1:0] upper_left_reg;

    // Per-pixel flags
    logic                       has_edge_reg;
    logic                       has_zero_reg;
    logic                       last_row_reg;

    // Gradient arithmetic
    logic signed [gme_pkg::DIFF_W-1:0]   d_reg;
    logic signed [gme_pkg::DIFF_W-1:0]   e_reg;
    logic signed [2*gme_pkg::DIFF_W-1:0] d_sq;
    logic signed [2*gme_pkg::DIFF_W-1:0] e_sq;
    logic [gme_pkg::SQ_W-1:0]            rem_reg;
    logic [gme_pkg::SQ_W-1:0]            res_reg;
    logic [gme_pkg::STEP_W-1:0]          step_reg;
    logic [gme_pkg::SQ_W-1:0]            root_bit;
    logic [gme_pkg::SQ_W-1:0]            trial;
    logic [gme_pkg::PROD_W-1:0]          prod;
    logic [gme_pkg::ROOT_W-1:0]          third;
    logic [gme_pkg::LEVEL_W-1:0]         level_reg;

    // Output register
    logic                        out_valid_reg;
    logic [gme_pkg::LEVEL_W-1:0] out_level_reg;
    logic                        out_last_reg;

    // Row and frame ends under the current size
    assign last_col = gme_pkg::SIZE_W'(col_reg) >= (size.width - gme_pkg::SIZE_W'(1));
    assign last_row = gme_pkg::SIZE_W'(row_reg) >= (size.height - gme_pkg::SIZE_W'(1));

    assign inten = gme_pkg::INTEN_W'(red) + gme_pkg::INTEN_W'(green)
                 + gme_pkg::INTEN_W'(blue);

    // Advance the raster counters and latch the pixel flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            has_edge_reg <= 1'b0;
            has_zero_reg <= 1'b0;
            last_row_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            has_edge_reg <= (row_reg != '0) && (col_reg != '0);
            has_zero_reg <= (row_reg != '0) && last_col;
            last_row_reg <= last_row;
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Read the entry above, then overwrite it with this pixel
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            above_reg         <= line_mem[col_reg];
            line_mem[col_reg] <= inten;
            pix_reg           <= inten;
        end
    end

    // Form differences and shift the neighbor window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            upper_left_reg <= '0;
        end
        else if (cmd.diff)
        begin
            left_reg       <= pix_reg;
            upper_left_reg <= above_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            d_reg <= $signed({1'b0, above_reg}) - $signed({1'b0, upper_left_reg});
            e_reg <= $signed({1'b0, left_reg}) - $signed({1'b0, upper_left_reg});
        end
    end

    assign d_sq = d_reg * d_reg;
    assign e_sq = e_reg * e_reg;

    // Square root: one bit pair per cycle, from the top pair down
    assign root_bit = gme_pkg::SQ_W'(1) << {step_reg, 1'b0};
    assign trial    = res_reg + root_bit;

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            rem_reg  <= gme_pkg::SQ_W'(d_sq) + gme_pkg::SQ_W'(e_sq);
            res_reg  <= '0;
            step_reg <= STEP_FIRST;
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + root_bit;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            step_reg <= step_reg - gme_pkg::STEP_W'(1);
        end
    end

    // Divide the root by three and clamp
    assign prod  = res_reg[gme_pkg::ROOT_W-1:0] * gme_pkg::RECIP_THIRD;
    assign third = prod[gme_pkg::PROD_W-1:gme_pkg::RECIP_SHIFT];

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
            level_reg <= (third > gme_pkg::ROOT_W'(gme_pkg::LEVEL_MAX))
                       ? gme_pkg::LEVEL_MAX : third[gme_pkg::LEVEL_W-1:0];
    end

    // Hold the result until the sink takes the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_edge || cmd.emit_zero)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_edge)
        begin
            out_level_reg <= level_reg;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.emit_zero)
        begin
            out_level_reg <= '0;
            out_last_reg  <= last_row_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign edge_level    = out_level_reg;
    assign last_of_frame = out_last_reg;

    assign status.has_edge  = has_edge_reg;
    assign status.has_zero  = has_zero_reg;
    assign status.root_last = (step_reg == '0);
    assign status.out_busy  = out_valid_reg && !out_ready;

endmodule

[design/gradient_magnitude_edge_map.sv]
// ----------------------------------------------------------------------------
// gradient_magnitude_edge_map: forward-difference edge map of an RGB stream
// Takes pixels in raster order and emits min(255, isqrt(D*D+E*E)/3) per pixel
// of the previous row, with 0 for the last column and last_of_frame on the
// final result of each frame.
// ----------------------------------------------------------------------------
// A first-row or first-column pixel goes from capture through the difference
// state back to idle; any other pixel also passes square, the 11-step bit-pair
// square root on one shared unit, scaling and an output transfer, and on the
// last column a second result, the zero. The previous row comes from a
// single-port line memory with a registered read. A finished result waits in
// the output register while the next pixel is taken; a stalled sink holds the
// sequencer only when a new result must be stored. A frame of W x H pixels
// gives (H-1)*W results. Width and height, clamped to [2, MAX_WIDTH] and
// [2, MAX_HEIGHT], are written over the APB port at byte addresses 0 and 4;
// the user must write them only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module gradient_magnitude_edge_map #(
    parameter int MAX_WIDTH  = gme_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gme_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gme_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gme_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gme_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    gme_pixel_if.sink                       pixel_in,
    gme_edge_if.source                      edge_out
);

    gme_pkg::gme_size_t   size;
    gme_pkg::gme_cmd_t    cmd;
    gme_pkg::gme_status_t status;

    // Configuration registers
    gme_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .size    (size)
    );

    // Sequencer
    gme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_in.valid),
        .in_ready (pixel_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    gme_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .size          (size),
        .cmd           (cmd),
        .status        (status),
        .red           (pixel_in.red),
        .green         (pixel_in.green),
        .blue          (pixel_in.blue),
        .out_valid     (edge_out.valid),
        .out_ready     (edge_out.ready),
        .edge_level    (edge_out.edge_level),
        .last_of_frame (edge_out.last_of_frame)
    );

endmodule

[bench/tb_gradient_magnitude_edge_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_magnitude_edge_map: self-checking bench for the edge map block
// Streams RGB frames of many sizes through the pixel channel and rebuilds
// every edge level and end-of-frame mark in a cycle-free model of the
// forward-difference gradient. Each result transfer is checked against the
// oldest pending level. Frame size goes through the APB port while the block
// is idle, including clamped, oversized, tallest and mid-frame sizes. Both sides
// idle at random, and one long output hold-off backs up the pixel input.
// ----------------------------------------------------------------------------
module tb_gradient_magnitude_edge_map;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_COLS       = gme_pkg::MAX_WIDTH_DEF;
    localparam int MAX_ROWS       = gme_pkg::MAX_HEIGHT_DEF;
    // extra wait after settling, before touching registers
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam int ITEMS_PER_MODE = 40;
    localparam int BATCH_CAP      = 40;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [gme_pkg::APB_ADDR_W-1:0] ADDR_IMAGE_WIDTH  =
        {gme_pkg::REG_WIDTH, 2'b00};
    localparam logic [gme_pkg::APB_ADDR_W-1:0] ADDR_IMAGE_HEIGHT =
        {gme_pkg::REG_HEIGHT, 2'b00};

    typedef struct packed {
        logic [gme_pkg::CHAN_W-1:0] red;
        logic [gme_pkg::CHAN_W-1:0] green;
        logic [gme_pkg::CHAN_W-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic [gme_pkg::LEVEL_W-1:0] level;
        logic                        last;
    } edge_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [gme_pkg::APB_ADDR_W-1:0] paddr;
    logic [gme_pkg::APB_DATA_W-1:0] pwdata;
    logic [gme_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    gme_pixel_if pix_if ();
    gme_edge_if  edge_if ();

    // Size registers as last written, and the frame position of the model
    logic [gme_pkg::CFG_W-1:0]   width_reg;
    logic [gme_pkg::CFG_W-1:0]   height_reg;
    logic [gme_pkg::INTEN_W-1:0] row_above [MAX_COLS];
    logic [gme_pkg::INTEN_W-1:0] left_inten;
    logic [gme_pkg::INTEN_W-1:0] upper_left_inten;
    int unsigned                 col_pos;
    int unsigned                 row_pos;

    rgb_pixel_t   pending_pixels [$];
    edge_result_t expected_edges [$];
    int unsigned  pushed_pixels;
    int unsigned  accepted_pixels;
    int unsigned  results_seen;
    int unsigned  mismatch_count;
    int unsigned  quiet_cycles;

    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    logic         hold_go;
    logic         hold_taken;
    int unsigned  hold_cycles_left;

    gradient_magnitude_edge_map uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .pixel_in (pix_if),
        .edge_out (edge_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned clamp_dim(logic [gme_pkg::CFG_W-1:0] v,
                                              int unsigned top);
        if (v < 2)
            return 2;
        if (v > top)
            return top;
        return 32'(v);
    endfunction

    // min(255, floor(isqrt(dx^2 + dy^2) / 3)), root built one bit at a time
    function automatic logic [gme_pkg::LEVEL_W-1:0] gradient_level(
        logic [gme_pkg::INTEN_W-1:0] own,
        logic [gme_pkg::INTEN_W-1:0] right,
        logic [gme_pkg::INTEN_W-1:0] lower);
        int          dx;
        int          dy;
        int unsigned energy;
        int unsigned root;
        int unsigned trial;
        int unsigned third;
        dx = int'(right) - int'(own);
        dy = int'(lower) - int'(own);
        energy = dx * dx + dy * dy;
        root = 0;
        for (int b = 10; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= energy)
                root = trial;
        end
        third = root / 3;
        return (third > gme_pkg::LEVEL_MAX) ? gme_pkg::LEVEL_MAX
                                            : third[gme_pkg::LEVEL_W-1:0];
    endfunction

    // Take one pixel: queue the levels it releases for the row above, then advance
    function automatic void advance_frame(rgb_pixel_t px);
        int unsigned                 w;
        int unsigned                 h;
        int unsigned                 inten;
        logic [gme_pkg::INTEN_W-1:0] above;
        logic                        at_row_end;
        logic                        at_frame_end;
        edge_result_t                r;
        w = clamp_dim(width_reg, MAX_COLS);
        h = clamp_dim(height_reg, MAX_ROWS);
        inten = px.red + px.green + px.blue;
        above = row_above[col_pos];
        at_row_end = (col_pos >= w - 1);
        at_frame_end = (row_pos >= h - 1);
        if (row_pos >= 1)
        begin
            if (col_pos >= 1)
            begin
                r.level = gradient_level(upper_left_inten, above, left_inten);
                r.last = 1'b0;
                expected_edges.push_back(r);
            end
            // last column always reads zero
            if (at_row_end)
            begin
                r.level = '0;
                r.last = at_frame_end;
                expected_edges.push_back(r);
            end
        end
        upper_left_inten = above;
        left_inten = inten[gme_pkg::INTEN_W-1:0];
        row_above[col_pos] = inten[gme_pkg::INTEN_W-1:0];
        if (at_row_end)
        begin
            col_pos = 0;
            row_pos = at_frame_end ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    function automatic void flag_mismatch(string field, int unsigned want, int unsigned got);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t: result %0d %s: expected %0d, got %0d",
                     $time, results_seen, field, want, got);
        mismatch_count++;
    endfunction

    function automatic logic [gme_pkg::CHAN_W-1:0] random_channel();
        logic [gme_pkg::CHAN_W-1:0] v;
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            default: v = gme_pkg::CHAN_W'($urandom_range(255));
        endcase
        return v;
    endfunction

    // Pixel source: advance on each transfer, idle at random
    always @(posedge clk)
    begin : pixel_source
        rgb_pixel_t px;
        if (!rst_n)
            pix_if.valid <= 1'b0;
        else if (!pix_if.valid || pix_if.ready)
        begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                px = pending_pixels.pop_front();
                pix_if.valid <= 1'b1;
                pix_if.red   <= px.red;
                pix_if.green <= px.green;
                pix_if.blue  <= px.blue;
            end
            else
                pix_if.valid <= 1'b0;
        end
    end

    // Edge sink: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin : edge_sink
        if (!rst_n)
        begin
            edge_if.ready <= 1'b0;
            hold_taken <= 1'b0;
            hold_cycles_left <= 0;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_cycles_left <= HOLDOFF_CYCLES;
            edge_if.ready <= 1'b0;
        end
        else if (hold_cycles_left != 0)
        begin
            hold_cycles_left <= hold_cycles_left - 1;
            edge_if.ready <= 1'b0;
        end
        else
            edge_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Observe both channels, check results, watch for a hang
    always @(posedge clk)
    begin : channel_watch
        rgb_pixel_t   px;
        edge_result_t want;
        if (rst_n)
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                px.red = pix_if.red;
                px.green = pix_if.green;
                px.blue = pix_if.blue;
                advance_frame(px);
                accepted_pixels++;
            end
            if (edge_if.valid && edge_if.ready)
            begin
                if (expected_edges.size() == 0)
                    flag_mismatch("arrived with none pending, edge_level", 0,
                                  edge_if.edge_level);
                else
                begin
                    want = expected_edges.pop_front();
                    if (edge_if.edge_level !== want.level)
                        flag_mismatch("edge_level", want.level, edge_if.edge_level);
                    if (edge_if.last_of_frame !== want.last)
                        flag_mismatch("last_of_frame", want.last, edge_if.last_of_frame);
                end
                results_seen++;
            end
            if ((pix_if.valid && pix_if.ready) || (edge_if.valid && edge_if.ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // APB write: setup cycle, access cycle, register takes the value on pready
    task automatic write_size(logic [gme_pkg::APB_ADDR_W-1:0] addr,
                              logic [gme_pkg::CFG_W-1:0] value);
        logic [gme_pkg::APB_DATA_W-1:0] word;
        word = $urandom();
        word[gme_pkg::CFG_W-1:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
    endtask

    task automatic queue_rgb(logic [gme_pkg::CHAN_W-1:0] r, logic [gme_pkg::CHAN_W-1:0] g,
                             logic [gme_pkg::CHAN_W-1:0] b);
        rgb_pixel_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        pending_pixels.push_back(px);
        pushed_pixels++;
    endtask

    task automatic queue_random_pixels(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            queue_rgb(random_channel(), random_channel(), random_channel());
    endtask

    // Wait until every pixel is taken and every level has come back
    task automatic settle();
        while (accepted_pixels != pushed_pixels || expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [gme_pkg::CFG_W-1:0] pick_size(int unsigned span);
        logic [gme_pkg::CFG_W-1:0] v;
        case ($urandom_range(9))
            0: v = gme_pkg::CFG_W'($urandom_range(1));
            1: v = gme_pkg::CFG_W'($urandom_range(span, 13));
            default: v = gme_pkg::CFG_W'($urandom_range(12, 2));
        endcase
        return v;
    endfunction

    initial
    begin : stimulus
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned cap;
        int unsigned count;
        int unsigned mode_items;

        // hold every input at a known value from time zero
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_if.valid = 1'b0;
        pix_if.red = '0;
        pix_if.green = '0;
        pix_if.blue = '0;
        edge_if.ready = 1'b0;
        hold_go = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 78;
        width_reg = gme_pkg::WIDTH_RESET;
        height_reg = gme_pkg::HEIGHT_RESET;
        left_inten = '0;
        upper_left_inten = '0;
        col_pos = 0;
        row_pos = 0;
        pushed_pixels = 0;
        accepted_pixels = 0;
        results_seen = 0;
        mismatch_count = 0;
        quiet_cycles = 0;
        for (int i = 0; i < MAX_COLS; i++)
            row_above[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset size: one full 640-pixel row and the start of the next
        queue_random_pixels(643);
        settle();
        // Shrink both sizes below the minimum mid-frame: row and frame end at once
        write_size(ADDR_IMAGE_WIDTH, 11'd1);
        write_size(ADDR_IMAGE_HEIGHT, 11'd0);
        queue_random_pixels(1);
        settle();

        // Small frame with black/white extremes and a few odd colors
        write_size(ADDR_IMAGE_WIDTH, 11'd4);
        write_size(ADDR_IMAGE_HEIGHT, 11'd3);
        queue_rgb(8'd0, 8'd0, 8'd0);
        queue_rgb(8'd255, 8'd255, 8'd255);
        queue_rgb(8'd0, 8'd0, 8'd0);
        queue_rgb(8'd255, 8'd255, 8'd255);
        queue_rgb(8'd255, 8'd255, 8'd255);
        queue_rgb(8'd0, 8'd0, 8'd0);
        queue_rgb(8'd255, 8'd0, 8'd0);
        queue_rgb(8'd0, 8'd255, 8'd0);
        queue_rgb(8'd0, 8'd0, 8'd255);
        queue_rgb(8'd128, 8'd64, 8'd32);
        queue_rgb(8'd255, 8'd255, 8'd255);
        queue_rgb(8'd0, 8'd0, 8'd0);
        settle();

        // Width above the limit, then cut the first row short and finish the frame
        write_size(ADDR_IMAGE_WIDTH, 11'd2047);
        write_size(ADDR_IMAGE_HEIGHT, 11'd2);
        queue_random_pixels(9);
        settle();
        write_size(ADDR_IMAGE_WIDTH, 11'd3);
        queue_random_pixels(4);
        settle();

        // Tallest setting: run ten rows, then cut the frame short
        write_size(ADDR_IMAGE_WIDTH, 11'd2);
        write_size(ADDR_IMAGE_HEIGHT, 11'd2047);
        queue_random_pixels(20);
        settle();
        write_size(ADDR_IMAGE_HEIGHT, 11'd5);
        queue_random_pixels(2);
        settle();

        // Random frames under three idle patterns
        for (int mode = 0; mode < 3; mode++)
        begin
            @(posedge clk);
            send_idle_pct <= (mode == 0) ? 21 : (mode == 1) ? 78 : 0;
            recv_idle_pct <= (mode == 0) ? 78 : (mode == 1) ? 21 : 0;
            mode_items = 0;

            if (mode == 2)
            begin
                // Stall the output long enough to back up the pixel input
                settle();
                write_size(ADDR_IMAGE_HEIGHT, 11'd20);
                if (row_pos == 0)
                    write_size(ADDR_IMAGE_WIDTH, 11'd4);
                @(posedge clk);
                hold_go <= 1'b1;
                queue_random_pixels(60);
                mode_items = 60;
            end

            while (mode_items < ITEMS_PER_MODE)
            begin
                settle();
                w_eff = clamp_dim(width_reg, MAX_COLS);
                if (row_pos == 0)
                begin
                    // rows not yet read back: any width is safe
                    if ($urandom_range(9) < 7)
                    begin
                        write_size(ADDR_IMAGE_WIDTH, pick_size(40));
                        write_size(ADDR_IMAGE_HEIGHT, pick_size(8));
                    end
                end
                else if ($urandom_range(3) == 0)
                begin
                    // mid-frame: only narrow, so every stored entry read was written
                    write_size(ADDR_IMAGE_WIDTH, gme_pkg::CFG_W'($urandom_range(w_eff, 0)));
                    if ($urandom_range(1) == 0)
                        write_size(ADDR_IMAGE_HEIGHT, gme_pkg::CFG_W'($urandom_range(8, 0)));
                end
                w_eff = clamp_dim(width_reg, MAX_COLS);
                h_eff = clamp_dim(height_reg, MAX_ROWS);
                cap = 2 * w_eff * h_eff;
                if (cap > BATCH_CAP)
                    cap = BATCH_CAP;
                count = $urandom_range(cap, 1);
                queue_random_pixels(count);
                mode_items += count;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
